// ===== rtl/dcf_pkg.sv =====
// ----------------------------------------------------------------------------
// dcf_pkg
// Shared types and constants for the directed cycle finder: word formats,
// operation codes, datapath commands and datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

package dcf_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int NODE_W        = 7;

  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 7'd64;

  localparam logic OP_EDGE   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
  } request_t;

  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] node;
    logic              last;
  } result_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_EDGE,
    DP_INIT,
    DP_SKIP,
    DP_PUSH_START,
    DP_ADVANCE,
    DP_PUSH,
    DP_FINISH,
    DP_RESTORE,
    DP_BACK,
    DP_MARK,
    DP_EMIT,
    DP_NONE,
    DP_CLEAR
  } dp_op_t;

  typedef struct packed {
    logic s_end;
    logic s_free;
    logic j_end;
    logic edge_hit;
    logic j_on_path;
    logic j_finished;
    logic stack_empty;
    logic top_is_j;
    logic stk_is_target;
    logic emit_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/dcf_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcf_ctrl
// Controller for the cycle finder: sequences edge loads, the depth-first
// walk, cycle marking, result emission and the final clear.
// ----------------------------------------------------------------------------
`default_nettype none

module dcf_ctrl
  import dcf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       operation,
  input  wire dp_status_t status,
  output dp_op_t          cmd,
  output logic            busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEEK,
    S_STEP,
    S_RESTORE,
    S_MARK,
    S_EMIT,
    S_NONE,
    S_CLEAR
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = DP_NOP;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (operation == OP_SEARCH) begin
            cmd        = DP_INIT;
            state_next = S_SEEK;
          end else begin
            cmd = DP_EDGE;
          end
        end
      end
      S_SEEK: begin
        if (status.s_end) begin
          state_next = S_NONE;
        end else if (status.s_free) begin
          cmd        = DP_PUSH_START;
          state_next = S_STEP;
        end else begin
          cmd = DP_SKIP;
        end
      end
      S_STEP: begin
        if (status.j_end) begin
          cmd        = DP_FINISH;
          state_next = status.stack_empty ? S_SEEK : S_RESTORE;
        end else if (!status.edge_hit || status.j_finished) begin
          cmd = DP_ADVANCE;
        end else if (status.j_on_path) begin
          cmd        = DP_BACK;
          state_next = status.top_is_j ? S_EMIT : S_MARK;
        end else begin
          cmd = DP_PUSH;
        end
      end
      S_RESTORE: begin
        cmd        = DP_RESTORE;
        state_next = S_STEP;
      end
      S_MARK: begin
        cmd = DP_MARK;
        if (status.stk_is_target) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd = DP_EMIT;
        if (status.emit_last) begin
          state_next = S_CLEAR;
        end
      end
      S_NONE: begin
        cmd        = DP_NONE;
        state_next = S_CLEAR;
      end
      S_CLEAR: begin
        cmd        = DP_CLEAR;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dcf_dpath.sv =====
// ----------------------------------------------------------------------------
// dcf_dpath
// Datapath for the cycle finder: adjacency memory with row valid bits,
// colour bit vectors, walk stack memory, cycle marks and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dcf_dpath
  import dcf_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
)
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [NODE_W-1:0] cfg_data,
  input  wire request_t          request,
  input  wire dp_op_t            cmd,
  output dp_status_t             status,
  output result_t                result,
  output logic                   strobe
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  typedef struct packed {
    logic [IW-1:0] node;
    logic [CW-1:0] nxt;
  } stk_entry_t;

  logic [NODE_W-1:0]    node_count;
  logic [CW-1:0]        n_lim;
  logic [CW-1:0]        s_cnt;
  logic [IW-1:0]        top_node;
  logic [CW-1:0]        top_next;
  logic [IW-1:0]        sdepth;
  logic [IW-1:0]        target;
  logic [IW-1:0]        max_node;
  logic [IW-1:0]        emit_idx;
  logic [MAX_NODES-1:0] on_path;
  logic [MAX_NODES-1:0] finished;
  logic [MAX_NODES-1:0] marks;
  logic [MAX_NODES-1:0] row_valid;
  logic [MAX_NODES-1:0] row_q;
  stk_entry_t           stk_q;

  logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
  stk_entry_t           stk_mem [MAX_NODES];

  logic [NODE_W-1:0]    from_m1;
  logic [NODE_W-1:0]    to_m1;
  logic [IW-1:0]        from_idx;
  logic [IW-1:0]        to_idx;
  logic                 edge_ok;
  logic                 adj_we;
  logic [MAX_NODES-1:0] adj_wdata;
  logic [MAX_NODES-1:0] adj_mask;
  logic [IW-1:0]        s_idx;
  logic [IW-1:0]        j_idx;
  logic [IW-1:0]        top_pick;
  logic                 row_rd;
  logic [IW-1:0]        row_addr;
  logic                 stk_we;
  logic                 stk_rd;
  logic [IW-1:0]        sdepth_m1;
  stk_entry_t           stk_wdata;
  logic [CW-1:0]        n_new;

  assign from_m1  = request.from_node - NODE_W'(1);
  assign to_m1    = request.to_node - NODE_W'(1);
  assign from_idx = from_m1[IW-1:0];
  assign to_idx   = to_m1[IW-1:0];
  assign edge_ok  = (request.from_node != '0) && (request.to_node != '0) &&
                    (request.from_node <= NODE_W'(MAX_NODES)) &&
                    (request.to_node <= NODE_W'(MAX_NODES));

  assign adj_we    = (cmd == DP_EDGE) && edge_ok;
  assign adj_wdata = {{(MAX_NODES-1){1'b0}}, 1'b1} << to_idx;
  assign adj_mask  = row_valid[from_idx] ? adj_wdata : '1;

  assign n_new = (node_count > NODE_W'(MAX_NODES)) ? CW'(MAX_NODES) : node_count[CW-1:0];

  assign s_idx     = s_cnt[IW-1:0];
  assign j_idx     = top_next[IW-1:0];
  assign sdepth_m1 = sdepth - IW'(1);
  assign top_pick  = (cmd == DP_MARK) ? stk_q.node : top_node;

  always_comb begin
    row_rd   = 1'b0;
    row_addr = s_idx;
    case (cmd)
      DP_PUSH_START: begin
        row_rd   = 1'b1;
        row_addr = s_idx;
      end
      DP_PUSH: begin
        row_rd   = 1'b1;
        row_addr = j_idx;
      end
      DP_RESTORE: begin
        row_rd   = 1'b1;
        row_addr = stk_q.node;
      end
      default: begin
        row_rd = 1'b0;
      end
    endcase
  end

  assign stk_we         = (cmd == DP_PUSH);
  assign stk_wdata.node = top_node;
  assign stk_wdata.nxt  = top_next + CW'(1);
  assign stk_rd         = ((cmd == DP_FINISH) || (cmd == DP_BACK) || (cmd == DP_MARK)) &&
                          (sdepth != '0);

  assign status.s_end         = (s_cnt >= n_lim);
  assign status.s_free        = !on_path[s_idx] && !finished[s_idx];
  assign status.j_end         = (top_next >= n_lim);
  assign status.edge_hit      = row_q[j_idx];
  assign status.j_on_path     = on_path[j_idx];
  assign status.j_finished    = finished[j_idx];
  assign status.stack_empty   = (sdepth == '0);
  assign status.top_is_j      = (top_node == j_idx);
  assign status.stk_is_target = (stk_q.node == target);
  assign status.emit_last     = (emit_idx == max_node);

  // adjacency memory, masked bit write, registered row read
  always_ff @(posedge clk) begin
    if (adj_we) begin
      for (int b = 0; b < MAX_NODES; b++) begin
        if (adj_mask[b]) begin
          adj_mem[from_idx][b] <= adj_wdata[b];
        end
      end
    end
    if (row_rd) begin
      row_q <= row_valid[row_addr] ? adj_mem[row_addr] : '0;
    end
  end

  // walk stack memory
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[sdepth] <= stk_wdata;
    end
    if (stk_rd) begin
      stk_q <= stk_mem[sdepth_m1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
      row_valid  <= '0;
      on_path    <= '0;
      finished   <= '0;
      marks      <= '0;
      sdepth     <= '0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_we) begin
        node_count <= cfg_data;
      end
      if (stk_rd) begin
        sdepth <= sdepth_m1;
      end
      case (cmd)
        DP_EDGE: begin
          if (edge_ok) begin
            row_valid[from_idx] <= 1'b1;
          end
        end
        DP_INIT: begin
          n_lim    <= n_new;
          s_cnt    <= '0;
          sdepth   <= '0;
          emit_idx <= '0;
        end
        DP_SKIP: begin
          s_cnt <= s_cnt + CW'(1);
        end
        DP_PUSH_START: begin
          top_node       <= s_idx;
          top_next       <= '0;
          on_path[s_idx] <= 1'b1;
        end
        DP_ADVANCE: begin
          top_next <= top_next + CW'(1);
        end
        DP_PUSH: begin
          sdepth         <= sdepth + IW'(1);
          top_node       <= j_idx;
          top_next       <= '0;
          on_path[j_idx] <= 1'b1;
        end
        DP_FINISH: begin
          finished[top_node] <= 1'b1;
          on_path[top_node]  <= 1'b0;
        end
        DP_RESTORE: begin
          top_node <= stk_q.node;
          top_next <= stk_q.nxt;
        end
        DP_BACK: begin
          marks[top_node] <= 1'b1;
          max_node        <= top_node;
          target          <= j_idx;
        end
        DP_MARK: begin
          marks[top_pick] <= 1'b1;
          if (top_pick > max_node) begin
            max_node <= top_pick;
          end
        end
        DP_EMIT: begin
          emit_idx <= emit_idx + IW'(1);
          if (marks[emit_idx]) begin
            strobe       <= 1'b1;
            result.found <= 1'b1;
            result.node  <= NODE_W'(emit_idx) + NODE_W'(1);
            result.last  <= (emit_idx == max_node);
          end
        end
        DP_NONE: begin
          strobe       <= 1'b1;
          result.found <= 1'b0;
          result.node  <= '0;
          result.last  <= 1'b1;
        end
        DP_CLEAR: begin
          row_valid <= '0;
          on_path   <= '0;
          finished  <= '0;
          marks     <= '0;
          sdepth    <= '0;
        end
        default: begin
          strobe <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/directed_cycle_finder_core.sv =====
// ----------------------------------------------------------------------------
// directed_cycle_finder_core
// Collects directed edges in an adjacency matrix and, on a search word, runs
// a depth-first walk that reports the nodes of the first cycle it meets.
//
//   channel   signals                  handshake
//   request   start, busy, request     taken when start is high and busy low
//   result    strobe, result           one cycle per word, cannot be held off
//   config    cfg_we, cfg_data         written when cfg_we is high
//
// An edge word leaves busy low, so edges load every cycle.
// A search word holds busy high through the scan of start nodes, the test of
// each neighbour, each finished node and restored parent, the marking of the
// cycle nodes below the current one, an emit step per node up to the highest
// cycle node and a clear; with no cycle, the scan ends, none is sent, then a clear.
// Reset is synchronous; it empties the graph and sets node_count to 64.
// ----------------------------------------------------------------------------
`default_nettype none

module directed_cycle_finder_core
  import dcf_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
)
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire request_t          request,
  output logic                   strobe,
  output result_t                result,
  input  wire logic              cfg_we,
  input  wire logic [NODE_W-1:0] cfg_data
);

  dp_op_t     cmd;
  dp_status_t status;

  dcf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (request.operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  dcf_dpath #(
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .request  (request),
    .cmd      (cmd),
    .status   (status),
    .result   (result),
    .strobe   (strobe)
  );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for directed_cycle_finder_core. A short table of edge
// and search words covers the empty graph, self loops on the end nodes,
// ignored edges, repeated edges, a three-node and a two-node cycle. Random graphs, chains
// closed by a back edge, noise edges and a full ring then run under several
// node_count settings. A built-in depth-first predictor works out each result
// word the table does not give, and the result port is checked word by word.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import dcf_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_ITEMS = 15;

  typedef struct {
    request_t word;
    bit       typed;
    result_t  want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  request_t          request = '0;
  logic              strobe;
  result_t           result;
  logic              cfg_we = 1'b0;
  logic [NODE_W-1:0] cfg_data = '0;

  logic [63:0]       graph_adj [64];
  logic [NODE_W-1:0] node_limit = NODE_COUNT_RST;
  result_t           pending_words [$];
  result_t           head_word;
  dir_row_t          dir_table [$];
  bit                failed = 1'b0;
  bit                gaps_on = 1'b1;
  int                items_sent = 0;
  int                stall_cycles = 0;

  directed_cycle_finder_core dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .strobe   (strobe),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic dir_row_t row(logic op, int a, int b, bit typed, logic f, int nd,
                                   logic l);
    dir_row_t r;
    r.word.operation = op;
    r.word.from_node = NODE_W'(a);
    r.word.to_node   = NODE_W'(b);
    r.typed          = typed;
    r.want.found     = f;
    r.want.node      = NODE_W'(nd);
    r.want.last      = l;
    return r;
  endfunction

  function automatic logic [NODE_W-1:0] pick_node(int m);
    if ($urandom_range(0, 7) == 0) return NODE_W'($urandom_range(1, 64));
    return NODE_W'($urandom_range(1, m));
  endfunction

  // depth-first walk over the stored graph, then clear it
  task automatic find_cycle(output result_t words[$]);
    logic [1:0]        col [64];
    logic [NODE_W-1:0] stk_node [64];
    logic [NODE_W-1:0] stk_next [64];
    logic [63:0]       marks;
    result_t           w;
    int                depth, n, top, v, j, k;
    bit                hit;
    words = {};
    for (int i = 0; i < 64; i++) col[i] = 2'd0;
    marks = '0;
    hit   = 1'b0;
    depth = 0;
    n = (node_limit > 7'd64) ? 64 : int'(node_limit);
    for (int s = 1; s <= n && !hit; s++) begin
      if (col[s-1] != 2'd0) continue;
      stk_node[0] = NODE_W'(s);
      stk_next[0] = 7'd1;
      col[s-1]    = 2'd1;
      depth       = 1;
      while (depth > 0 && !hit) begin
        top = depth - 1;
        v   = int'(stk_node[top]);
        j   = int'(stk_next[top]);
        if (j > n) begin
          col[v-1] = 2'd2;
          depth--;
        end else begin
          stk_next[top] = NODE_W'(j + 1);
          if (graph_adj[v-1][j-1]) begin
            if (col[j-1] == 2'd0) begin
              stk_node[depth] = NODE_W'(j);
              stk_next[depth] = 7'd1;
              col[j-1]        = 2'd1;
              depth++;
            end else if (col[j-1] == 2'd1) begin
              k = 0;
              while (k < depth && int'(stk_node[k]) != j) k++;
              while (k < depth) begin
                marks[stk_node[k]-1] = 1'b1;
                k++;
              end
              hit = 1'b1;
            end
          end
        end
      end
    end
    for (int i = 0; i < 64; i++) begin
      if (marks[i]) begin
        w.found = 1'b1;
        w.node  = NODE_W'(i + 1);
        w.last  = 1'b0;
        words.push_back(w);
      end
    end
    if (words.size() > 0) begin
      words[$].last = 1'b1;
    end else begin
      w = '0;
      w.last = 1'b1;
      words.push_back(w);
    end
    for (int i = 0; i < 64; i++) graph_adj[i] = '0;
  endtask

  task automatic send_word(input request_t w, input bit typed, input result_t want);
    result_t outcome [$];
    int      gaps;
    bit      in_range;
    gaps = 0;
    while (gaps_on && $urandom_range(0, 99) < 37) gaps++;
    if (gaps > 0) begin
      start <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    start   <= 1'b1;
    request <= w;
    do @(posedge clk); while (busy);
    in_range = w.from_node >= 7'd1 && w.from_node <= 7'd64 &&
               w.to_node >= 7'd1 && w.to_node <= 7'd64;
    if (w.operation == OP_EDGE) begin
      if (in_range) begin
        graph_adj[w.from_node-1][w.to_node-1] = 1'b1;
        items_sent++;
      end
    end else begin
      items_sent++;
      find_cycle(outcome);
      if (typed) pending_words.push_back(want);
      else foreach (outcome[i]) pending_words.push_back(outcome[i]);
    end
  endtask

  task automatic send_edge(input int a, input int b);
    request_t w;
    w.operation = OP_EDGE;
    w.from_node = NODE_W'(a);
    w.to_node   = NODE_W'(b);
    send_word(w, 1'b0, '0);
  endtask

  task automatic send_search();
    request_t w;
    w.operation = OP_SEARCH;
    w.from_node = NODE_W'($urandom_range(0, 127));
    w.to_node   = NODE_W'($urandom_range(0, 127));
    send_word(w, 1'b0, '0);
  endtask

  // block must be idle: drain results and let the clear finish
  task automatic set_node_count(input logic [NODE_W-1:0] value);
    start <= 1'b0;
    while (pending_words.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    node_limit = value;
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word found=%0d node=%0d last=%0d", $time,
                 result.found, result.node, result.last);
        failed = 1'b1;
      end else begin
        head_word = pending_words.pop_front();
        if (result.found !== head_word.found || result.node !== head_word.node ||
            result.last !== head_word.last) begin
          $display("%0t: expected found=%0d node=%0d last=%0d, got found=%0d node=%0d last=%0d",
                   $time, head_word.found, head_word.node, head_word.last,
                   result.found, result.node, result.last);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[directed_cycle_finder_core] ERROR");
      $finish;
    end
  end

  initial begin
    logic [NODE_W-1:0] counts [10];
    int                m, kind, len, base, phase_start, a;
    counts = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd6, 7'd65, 7'd16, 7'd3, 7'd64, 7'd40};
    for (int i = 0; i < 64; i++) graph_adj[i] = '0;

    dir_table.push_back(row(OP_SEARCH, 0, 0, 1, 1'b0, 0, 1'b1));
    dir_table.push_back(row(OP_EDGE, 64, 64, 0, 1'b0, 0, 1'b0));
    dir_table.push_back(row(OP_SEARCH, 127, 127, 1, 1'b1, 64, 1'b1));
    dir_table.push_back(row(OP_EDGE, 1, 1, 0, 1'b0, 0, 1'b0));
    dir_table.push_back(row(OP_SEARCH, 0, 0, 1, 1'b1, 1, 1'b1));
    dir_table.push_back(row(OP_EDGE, 0, 5, 0, 1'b0, 0, 1'b0));
    dir_table.push_back(row(OP_EDGE, 5, 0, 0, 1'b0, 0, 1'b0));
    dir_table.push_back(row(OP_EDGE, 65, 65, 0, 1'b0, 0, 1'b0));
    dir_table.push_back(row(OP_EDGE, 127, 127, 0, 1'b0, 0, 1'b0));
    dir_table.push_back(row(OP_SEARCH, 0, 0, 1, 1'b0, 0, 1'b1));
    dir_table.push_back(row(OP_EDGE, 1, 2, 0, 1'b0, 0, 1'b0));
    dir_table.push_back(row(OP_EDGE, 2, 3, 0, 1'b0, 0, 1'b0));
    dir_table.push_back(row(OP_EDGE, 3, 1, 0, 1'b0, 0, 1'b0));
    dir_table.push_back(row(OP_EDGE, 1, 2, 0, 1'b0, 0, 1'b0));
    dir_table.push_back(row(OP_SEARCH, 0, 0, 0, 1'b0, 0, 1'b0));
    dir_table.push_back(row(OP_EDGE, 64, 63, 0, 1'b0, 0, 1'b0));
    dir_table.push_back(row(OP_EDGE, 63, 64, 0, 1'b0, 0, 1'b0));
    dir_table.push_back(row(OP_SEARCH, 0, 0, 0, 1'b0, 0, 1'b0));
    dir_table.push_back(row(OP_EDGE, 1, 2, 0, 1'b0, 0, 1'b0));
    dir_table.push_back(row(OP_EDGE, 2, 3, 0, 1'b0, 0, 1'b0));
    dir_table.push_back(row(OP_SEARCH, 0, 0, 1, 1'b0, 0, 1'b1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_table[i]) send_word(dir_table[i].word, dir_table[i].typed, dir_table[i].want);

    for (int p = 0; p < 10; p++) begin
      set_node_count(counts[p]);
      gaps_on = !(p == 4 || p == 5);
      m = (counts[p] == 7'd0) ? 4 : ((counts[p] > 7'd64) ? 64 : int'(counts[p]));
      if (p == 0) begin
        // full ring: every node on the cycle
        for (int i = 1; i < 64; i++) send_edge(i, i + 1);
        send_edge(64, 1);
        send_search();
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
          len = $urandom_range(0, 6);
          repeat (len) send_edge(pick_node(m), pick_node(m));
          send_search();
        end else if (kind < 80) begin
          len  = $urandom_range(1, (m < 10) ? m : 10);
          base = $urandom_range(1, m - len + 1);
          for (int i = 0; i < len - 1; i++) send_edge(base + i, base + i + 1);
          send_edge(base + len - 1, base + $urandom_range(0, len - 1));
          if ($urandom_range(0, 1) == 1) send_edge(pick_node(m), pick_node(m));
          send_search();
        end else if (kind < 92) begin
          len = $urandom_range(1, 3);
          repeat (len) begin
            a = $urandom_range(0, 127);
            send_edge(a, $urandom_range(0, 127));
          end
        end else begin
          send_search();
        end
      end
    end
    send_search();

    start <= 1'b0;
    while (pending_words.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (!failed) begin
      $display("[directed_cycle_finder_core] OK");
    end else begin
      $display("[directed_cycle_finder_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
